// ===== rtl/swrh_pkg.sv =====
package swrh_pkg;

  localparam int MAX_RADIUS   = 8;
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_REGIONS  = 16;
  localparam int HEIGHT_LIMIT = 1024;

  localparam int PAD_COLS   = MAX_WIDTH + 2 * MAX_RADIUS;
  localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
  localparam int LBL_DEPTH  = STORE_ROWS * PAD_COLS;
  localparam int LBL_AW     = $clog2(LBL_DEPTH);
  localparam int COL_AW     = $clog2(PAD_COLS);
  localparam int ROW_W      = $clog2(STORE_ROWS);
  localparam int CNT_W      = $clog2(STORE_ROWS + 1);
  localparam int WIN_W      = $clog2(STORE_ROWS * STORE_ROWS + 1);
  localparam int WORD_W     = MAX_REGIONS * CNT_W;

  localparam int LABEL_W  = 4;
  localparam int RAD_W    = 4;
  localparam int DIM_W    = 11;
  localparam int RC_W     = 5;
  localparam int PIX_W    = 10;
  localparam int BIN_W    = 4;
  localparam int SHARE_W  = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION = 2'd3;

  // share = (count * ceil(2^32 / area)) >> 17, exact for count <= area <= 289
  localparam int RECIP_W = 33;
  localparam int PROD_W  = RECIP_W + WIN_W;
  localparam int SHIFT   = 17;
  localparam logic [SHARE_W-1:0] SHARE_ONE = 16'd32768;

  localparam logic [RECIP_W-1:0] RECIP_TAB [0:MAX_RADIUS] = '{
    33'((64'd4294967296 + 64'd0)   / 64'd1),
    33'((64'd4294967296 + 64'd8)   / 64'd9),
    33'((64'd4294967296 + 64'd24)  / 64'd25),
    33'((64'd4294967296 + 64'd48)  / 64'd49),
    33'((64'd4294967296 + 64'd80)  / 64'd81),
    33'((64'd4294967296 + 64'd120) / 64'd121),
    33'((64'd4294967296 + 64'd168) / 64'd169),
    33'((64'd4294967296 + 64'd224) / 64'd225),
    33'((64'd4294967296 + 64'd288) / 64'd289)
  };

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [WIN_W-1:0] win_t;

endpackage

// ===== rtl/swrh_in_if.sv =====
interface swrh_in_if;
  import swrh_pkg::*;
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] region_label;
  modport source (output valid, output region_label, input ready);
  modport sink (input valid, input region_label, output ready);
endinterface

// ===== rtl/swrh_out_if.sv =====
interface swrh_out_if;
  import swrh_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [BIN_W-1:0]   bin_index;
  logic [SHARE_W-1:0] bin_share;
  logic               last_bin;
  modport source (output valid, output pixel_x, output pixel_y, output bin_index,
                  output bin_share, output last_bin, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input bin_index,
                input bin_share, input last_bin, output ready);
endinterface

// ===== rtl/swrh_cfg_if.sv =====
interface swrh_cfg_if;
  import swrh_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/swrh_ram.sv =====
module swrh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/sliding_window_region_histogram_core.sv =====
// channel | dir | beat contents
// cfg_ch  | in  | index, data (radius, width, height, region count)
// in_ch   | in  | region_label, one padded map cell in raster order
// out_ch  | out | pixel_x, pixel_y, bin_index, bin_share, last_bin
// An input cell goes through a label/column read, a window-edge column read
// and a write back; a cell that closes a window then passes its bins one by
// one through the multiplier stage, which a stalled out_ch holds.
// The single read port of the column-count memory forces the two separate reads.
// Reset is synchronous; column counts need no clearing pass: row 0 of a frame
// reads them as zero. A stalled out_ch holds the bin pipeline and in_ch.
module sliding_window_region_histogram_core (
  input  logic       clk,
  input  logic       rst_n,
  swrh_cfg_if.sink   cfg_ch,
  swrh_in_if.sink    in_ch,
  swrh_out_if.source out_ch
);
  import swrh_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD2  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [RAD_W-1:0] radius_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic [RC_W-1:0]  regions_r;

  logic [RAD_W-1:0] r_eff;
  logic [DIM_W-1:0] w_eff, h_eff, pw, ph, two_r;
  logic [RC_W-1:0]  rc_eff;
  logic [CNT_W-1:0] k;

  logic [DIM_W-1:0] cx_r, ry_r;
  logic [ROW_W-1:0] srow_r;
  logic [DIM_W-1:0] cx_in, ry_in;
  logic [ROW_W-1:0] srow_in;
  logic             norm;

  logic [LABEL_W-1:0] lbl_r, old_lbl_r;
  logic [LBL_AW-1:0]  laddr_r, laddr_in;
  logic               ry0_r, dec_r, win_r, sub_r, emit_r, cx0_r;
  logic [WORD_W-1:0]  colw_r;
  logic [PIX_W-1:0]   px_r, py_r;

  win_t wc_r [MAX_REGIONS];
  win_t wc_nxt [MAX_REGIONS];
  logic [WORD_W-1:0] neww;

  logic               lbl_we;
  logic [LABEL_W-1:0] lbl_rdata;
  logic [COL_AW-1:0]  col_raddr;
  logic [WORD_W-1:0]  col_rdata;
  logic               col_we;

  logic [BIN_W-1:0]   bin_r;
  logic               mul_v_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PIX_W-1:0]   mx_r, my_r;
  logic [BIN_W-1:0]   mbin_r;
  logic               mlast_r;
  logic               out_load, mul_take, bin_last;
  logic [PROD_W-SHIFT-1:0] q;

  logic in_acc, cfg_acc;

  always_comb begin
    r_eff  = (radius_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_r;
    w_eff  = (width_r == '0) ? DIM_W'(1) :
             (width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_r;
    h_eff  = (height_r == '0) ? DIM_W'(1) :
             (height_r > DIM_W'(HEIGHT_LIMIT)) ? DIM_W'(HEIGHT_LIMIT) : height_r;
    rc_eff = (regions_r == '0) ? RC_W'(1) :
             (regions_r > RC_W'(MAX_REGIONS)) ? RC_W'(MAX_REGIONS) : regions_r;
    two_r  = DIM_W'({r_eff, 1'b0});
    k      = CNT_W'({r_eff, 1'b1});
    pw     = w_eff + two_r;
    ph     = h_eff + two_r;
  end

  assign norm     = (cx_r >= pw) || (ry_r >= ph);
  assign cx_in    = norm ? '0 : cx_r;
  assign ry_in    = norm ? '0 : ry_r;
  assign srow_in  = norm ? '0 : srow_r;
  assign laddr_in = LBL_AW'(srow_in) * LBL_AW'(PAD_COLS) + LBL_AW'(cx_in);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  swrh_ram #(.WIDTH(LABEL_W), .DEPTH(LBL_DEPTH)) u_label_ram (
    .clk   (clk),
    .we    (lbl_we),
    .waddr (laddr_r),
    .wdata (lbl_r),
    .raddr (laddr_in),
    .rdata (lbl_rdata)
  );

  assign col_raddr = (state_r == ST_RD2) ? COL_AW'(cx_r - DIM_W'(k)) : COL_AW'(cx_in);

  swrh_ram #(.WIDTH(WORD_W), .DEPTH(PAD_COLS)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (COL_AW'(cx_r)),
    .wdata (neww),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  assign lbl_we = (state_r == ST_UPD);
  assign col_we = (state_r == ST_UPD);

  // column and window update, one lane per region
  always_comb begin
    for (int b = 0; b < MAX_REGIONS; b++) begin
      cnt_t c;
      cnt_t s;
      win_t t;
      c = ry0_r ? '0 : colw_r[b*CNT_W +: CNT_W];
      if (dec_r && old_lbl_r == LABEL_W'(b) && c != '0) begin
        c = c - CNT_W'(1);
      end
      if (lbl_r == LABEL_W'(b)) begin
        c = c + CNT_W'(1);
      end
      neww[b*CNT_W +: CNT_W] = c;
      s = col_rdata[b*CNT_W +: CNT_W];
      t = cx0_r ? '0 : wc_r[b];
      if (win_r) begin
        t = t + WIN_W'(c);
        if (sub_r) begin
          t = (t >= WIN_W'(s)) ? t - WIN_W'(s) : '0;
        end
      end
      wc_nxt[b] = t;
    end
  end

  assign out_load = mul_v_r && (!out_ch.valid || out_ch.ready);
  assign mul_take = !mul_v_r || out_load;
  assign bin_last = (RC_W'(bin_r) + RC_W'(1) == rc_eff);
  assign q        = prod_r[PROD_W-1:SHIFT];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = emit_r ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (mul_take && bin_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      radius_r  <= RAD_W'(1);
      width_r   <= DIM_W'(MAX_WIDTH);
      height_r  <= DIM_W'(HEIGHT_LIMIT);
      regions_r <= RC_W'(MAX_REGIONS);
      cx_r      <= '0;
      ry_r      <= '0;
      srow_r    <= '0;
      mul_v_r   <= 1'b0;
      out_ch.valid <= 1'b0;
      bin_r     <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_acc) begin
        case (cfg_ch.index)
          REG_RADIUS: radius_r  <= cfg_ch.data[RAD_W-1:0];
          REG_WIDTH:  width_r   <= cfg_ch.data[DIM_W-1:0];
          REG_HEIGHT: height_r  <= cfg_ch.data[DIM_W-1:0];
          REG_REGION: regions_r <= cfg_ch.data[RC_W-1:0];
          default: ;
        endcase
        cx_r   <= '0;
        ry_r   <= '0;
        srow_r <= '0;
      end else if (in_acc) begin
        cx_r   <= cx_in;
        ry_r   <= ry_in;
        srow_r <= srow_in;
      end else if (state_r == ST_UPD) begin
        // advance the frame position
        if (cx_r + DIM_W'(1) >= pw) begin
          cx_r <= '0;
          if (ry_r + DIM_W'(1) >= ph) begin
            ry_r   <= '0;
            srow_r <= '0;
          end else begin
            ry_r   <= ry_r + DIM_W'(1);
            srow_r <= (CNT_W'(srow_r) + CNT_W'(1) == k) ? '0 : srow_r + ROW_W'(1);
          end
        end else begin
          cx_r <= cx_r + DIM_W'(1);
        end
      end

      if (state_r == ST_UPD) begin
        bin_r <= '0;
      end else if (state_r == ST_EMIT && mul_take) begin
        bin_r <= bin_r + BIN_W'(1);
      end

      if (state_r == ST_EMIT && mul_take) begin
        mul_v_r <= 1'b1;
      end else if (out_load) begin
        mul_v_r <= 1'b0;
      end

      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lbl_r   <= in_ch.region_label;
      laddr_r <= laddr_in;
      ry0_r   <= (ry_in == '0);
      cx0_r   <= (cx_in == '0);
      dec_r   <= (ry_in >= DIM_W'(k));
      win_r   <= (ry_in >= two_r);
      sub_r   <= (cx_in >= DIM_W'(k));
      emit_r  <= (ry_in >= two_r) && (cx_in >= two_r);
      px_r    <= PIX_W'(cx_in - two_r);
      py_r    <= PIX_W'(ry_in - two_r);
    end
    if (state_r == ST_RD2) begin
      colw_r    <= col_rdata;
      old_lbl_r <= lbl_rdata;
    end
    if (state_r == ST_UPD) begin
      for (int b = 0; b < MAX_REGIONS; b++) begin
        wc_r[b] <= wc_nxt[b];
      end
    end
    if (state_r == ST_EMIT && mul_take) begin
      prod_r  <= PROD_W'(wc_r[bin_r]) * PROD_W'(RECIP_TAB[r_eff]);
      mx_r    <= px_r;
      my_r    <= py_r;
      mbin_r  <= bin_r;
      mlast_r <= bin_last;
    end
    if (out_load) begin
      out_ch.pixel_x   <= mx_r;
      out_ch.pixel_y   <= my_r;
      out_ch.bin_index <= mbin_r;
      out_ch.bin_share <= (q > (PROD_W-SHIFT)'(SHARE_ONE)) ? SHARE_ONE : q[SHARE_W-1:0];
      out_ch.last_bin  <= mlast_r;
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_RD2) else $error("accepted cell did not start read");

  a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_bin |-> RC_W'(out_ch.bin_index) + RC_W'(1) == rc_eff)
    else $error("last bin flag on wrong bin");

  a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.bin_share <= SHARE_ONE) else $error("share above one");

  a_emit_only_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> emit_r) else $error("emitting without a full window");

  a_mul_holds: assert property (@(posedge clk) disable iff (!rst_n)
    mul_v_r && !out_load |=> mul_v_r) else $error("bin dropped in multiplier stage");

endmodule
